>>> rtl/core/ep2c_pkg.sv
// Shared types, constants and lookup functions for the epoch-seconds calendar converter.
`default_nettype none

package ep2c_pkg;

  localparam int unsigned SecW   = 32;
  localparam int unsigned RemW   = 11;
  localparam int unsigned OutW   = 48;
  localparam int unsigned DaysW  = 16;

  localparam logic [DaysW-1:0] DaysToEpoch  = 16'd731;
  localparam logic [DaysW-1:0] EpochWeekday = 16'd4;
  localparam logic [7:0]       BaseYear     = 8'd68;
  localparam logic [RemW-1:0]  Feb29Index   = 11'd59;
  localparam logic [RemW-1:0]  DaysLeap     = 11'd366;

  typedef enum logic [2:0] {
    DIV_SEC,
    DIV_MIN,
    DIV_HOUR,
    DIV_QUAD,
    DIV_YEAR,
    DIV_WEEK
  } div_sel_t;

  typedef struct packed {
    logic            start;
    div_sel_t        sel;
    logic [SecW-1:0] x;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [SecW-1:0] quot;
    logic [RemW-1:0] rem;
  } div_rsp_t;

  function automatic logic [31:0] div_magic(input div_sel_t sel);
    logic [31:0] m;
    case (sel)
      DIV_SEC:  m = 32'h8888_8889;
      DIV_MIN:  m = 32'h8888_8889;
      DIV_HOUR: m = 32'hAAAA_AAAB;
      DIV_QUAD: m = 32'd2939745;
      DIV_YEAR: m = 32'd11767034;
      DIV_WEEK: m = 32'd613566757;
      default:  m = 32'd0;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] div_shift(input div_sel_t sel);
    logic [5:0] s;
    case (sel)
      DIV_SEC:  s = 6'd37;
      DIV_MIN:  s = 6'd37;
      DIV_HOUR: s = 6'd36;
      default:  s = 6'd32;
    endcase
    return s;
  endfunction

  function automatic logic [RemW-1:0] div_const(input div_sel_t sel);
    logic [RemW-1:0] c;
    case (sel)
      DIV_SEC:  c = 11'd60;
      DIV_MIN:  c = 11'd60;
      DIV_HOUR: c = 11'd24;
      DIV_QUAD: c = 11'd1461;
      DIV_YEAR: c = 11'd365;
      DIV_WEEK: c = 11'd7;
      default:  c = 11'd1;
    endcase
    return c;
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      4'd12:   d = 9'd365;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ep2c_divc.sv
// Shared constant divider: reciprocal multiply, then remainder and one-step correction.
`default_nettype none

module ep2c_divc import ep2c_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0]      prod;
  logic [SecW-1:0]  xr;
  div_sel_t         sel_r;
  logic             fix;

  logic [RemW-1:0]  dv;
  logic [63:0]      prod_sh;
  logic [SecW-1:0]  q0;
  logic [42:0]      qc;
  logic [SecW-1:0]  r0;
  logic [SecW-1:0]  r1;
  logic             corr;

  always_comb begin
    dv      = div_const(sel_r);
    prod_sh = prod >> div_shift(sel_r);
    q0      = prod_sh[SecW-1:0];
    qc      = 43'(q0) * 43'(dv);
    r0      = xr - qc[SecW-1:0];
    corr    = r0 >= 32'(dv);
    r1      = corr ? (r0 - 32'(dv)) : r0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fix      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      fix      <= req.start;
      rsp.done <= fix;
    end
    if (req.start) begin
      prod  <= 64'(req.x) * 64'(div_magic(req.sel));
      xr    <= req.x;
      sel_r <= req.sel;
    end
    if (fix) begin
      rsp.quot <= corr ? (q0 + 32'd1) : q0;
      rsp.rem  <= r1[RemW-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/epoch_seconds_to_calendar.sv
// Epoch seconds to calendar date converter, top level with sequencer and result register.
//
// Takes one unsigned 32-bit count of seconds since 1970-01-01 and returns the broken-down
// calendar time. Leap years follow the plain four-year rule, so 2100 counts as leap. One
// shared constant divider does six divisions in turn (seconds, minutes, hours, four-year
// periods, years, weekday), followed by a month search that steps down from December one
// month per cycle, and the result is then loaded into the result register. The sequencer
// returns to idle as the result is loaded, and only then accepts the next item.
// The result register lets the next item be accepted while the last result is waiting.
`default_nettype none

module epoch_seconds_to_calendar import ep2c_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [31:0]     s_tdata,   // epoch_seconds[31:0]
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [OutW-1:0] m_tdata    // second_of_minute[5:0], minute_of_hour[11:6],
                                     // hour_of_day[16:12], day_of_month[21:17],
                                     // month_number[25:22], years_since_1900[33:26],
                                     // day_of_year[42:34], weekday[45:43], zero[47:46]
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEC,
    S_MIN,
    S_HOUR,
    S_QUAD,
    S_YEAR,
    S_WEEK,
    S_MONTH,
    S_FINISH
  } state_t;

  state_t          state;
  div_req_t        req;
  div_rsp_t        rsp;

  logic [5:0]      sec;
  logic [5:0]      mn;
  logic [4:0]      hr;
  logic [DaysW-1:0] days;
  logic [DaysW-1:0] since68;
  logic            yday_adj;
  logic [7:0]      year;
  logic [8:0]      yday;
  logic [2:0]      wday;
  logic [3:0]      mon;
  logic [4:0]      mday;
  logic [OutW-1:0] out_data;

  logic [5:0]      leapdays;
  logic            past_feb29;
  logic [8:0]      mstart;
  logic [8:0]      mday_full;
  logic            launch;

  ep2c_divc u_divc (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    past_feb29 = rsp.rem > Feb29Index;
    leapdays   = rsp.quot[5:0] + {5'd0, past_feb29};
    mstart     = month_start(mon - 4'd1) +
                 {8'd0, (mon > 4'd2) && (year[1:0] == 2'd0)};
    mday_full  = yday - mstart + 9'd1;
    launch     = ((state == S_IDLE) && s_tvalid) ||
                 (rsp.done && (state inside {S_SEC, S_MIN, S_HOUR, S_QUAD, S_YEAR}));
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req.start <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      req.start <= launch;
      if ((state == S_FINISH) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req.sel   <= DIV_SEC;
            req.x     <= s_tdata;
            state     <= S_SEC;
          end
        end
        S_SEC: begin
          if (rsp.done) begin
            sec       <= rsp.rem[5:0];
            req.sel   <= DIV_MIN;
            req.x     <= rsp.quot;
            state     <= S_MIN;
          end
        end
        S_MIN: begin
          if (rsp.done) begin
            mn        <= rsp.rem[5:0];
            req.sel   <= DIV_HOUR;
            req.x     <= rsp.quot;
            state     <= S_HOUR;
          end
        end
        S_HOUR: begin
          if (rsp.done) begin
            hr        <= rsp.rem[4:0];
            days      <= rsp.quot[DaysW-1:0];
            since68   <= rsp.quot[DaysW-1:0] + DaysToEpoch;
            req.sel   <= DIV_QUAD;
            req.x     <= 32'(rsp.quot[DaysW-1:0] + DaysToEpoch);
            state     <= S_QUAD;
          end
        end
        S_QUAD: begin
          if (rsp.done) begin
            yday_adj  <= past_feb29 && (rsp.rem < DaysLeap);
            req.sel   <= DIV_YEAR;
            req.x     <= 32'(since68 - {10'd0, leapdays});
            state     <= S_YEAR;
          end
        end
        S_YEAR: begin
          if (rsp.done) begin
            year      <= rsp.quot[7:0] + BaseYear;
            yday      <= rsp.rem[8:0] + {8'd0, yday_adj};
            req.sel   <= DIV_WEEK;
            req.x     <= 32'(days + EpochWeekday);
            state     <= S_WEEK;
          end
        end
        S_WEEK: begin
          if (rsp.done) begin
            wday  <= rsp.rem[2:0];
            mon   <= 4'd12;
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if ((yday >= mstart) || (mon == 4'd1)) begin
            mday  <= mday_full[4:0];
            state <= S_FINISH;
          end else begin
            mon <= mon - 4'd1;
          end
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            out_data <= {2'd0, wday, yday, year, mon, mday, hr, mn, sec};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_SEC || state == S_MIN || state == S_HOUR ||
                  state == S_QUAD || state == S_YEAR || state == S_WEEK))
    else $error("divider result arrived outside a division step");

  a_accept_starts_divide: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (req.start && state == S_SEC))
    else $error("accepted item did not start the first division");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FINISH))
    else $error("result presented without finishing a conversion");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[25:22] >= 4'd1 && m_tdata[25:22] <= 4'd12))
    else $error("month out of range");

endmodule

`default_nettype wire

>>> test/tb_epoch_seconds_to_calendar.sv
// Self-checking testbench for epoch_seconds_to_calendar: predictor, stream driver and monitor.
`default_nettype none

module tb_epoch_seconds_to_calendar;
  import ep2c_pkg::*;

  typedef struct packed {
    logic [1:0] pad;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
    logic [7:0] years_since_1900;
    logic [3:0] month_number;
    logic [4:0] day_of_month;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
  } calendar_t;

  localparam int unsigned SecsPerDay = 86400;
  localparam int unsigned DaysQuad   = 1461;
  localparam int unsigned EndLatency = 64;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [31:0]     s_tdata = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [OutW-1:0] m_tdata;

  logic [31:0] pending_seconds [$];
  calendar_t   expected_dates [$];
  int unsigned cum_days [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned items_sent = 0;
  int unsigned dates_checked = 0;
  int unsigned errors = 0;

  epoch_seconds_to_calendar u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic calendar_t to_calendar(input logic [31:0] secs);
    calendar_t   c;
    int unsigned mins, hours, days, since68, quads, inquad, leapdays;
    int unsigned yrs, yday, year, mon, start;
    mins     = secs / 60;
    hours    = mins / 60;
    days     = hours / 24;
    since68  = days + 365 + 366;
    quads    = since68 / DaysQuad;
    inquad   = since68 % DaysQuad;
    leapdays = quads + ((inquad > 59) ? 1 : 0);
    yrs      = (since68 - leapdays) / 365;
    yday     = since68 - yrs * 365 - leapdays;
    if (inquad > 59 && inquad < 366) yday++;
    year  = yrs + 68;
    mon   = 13;
    start = 366;
    while (yday < start && mon > 1) begin
      mon--;
      start = cum_days[mon - 1];
      if (mon > 2 && year % 4 == 0) start++;
    end
    c                  = '0;
    c.second_of_minute = 6'(secs - mins * 60);
    c.minute_of_hour   = 6'(mins - hours * 60);
    c.hour_of_day      = 5'(hours - days * 24);
    c.day_of_month     = 5'(yday - start + 1);
    c.month_number     = 4'(mon);
    c.years_since_1900 = 8'(year);
    c.day_of_year      = 9'(yday);
    c.weekday          = 3'((days + 4) % 7);
    return c;
  endfunction

  // boundaries of days, months and years get extra weight
  function automatic logic [31:0] pick_seconds();
    logic [63:0] t;
    int unsigned y, d;
    case ($urandom_range(3))
      0, 1: t = 64'($urandom());
      2: begin
        d = $urandom_range(49709);
        t = 64'(d) * SecsPerDay +
            ($urandom_range(1) ? 86399 - $urandom_range(3) : $urandom_range(3));
      end
      default: begin
        y = $urandom_range(136);
        case ($urandom_range(4))
          0: d = 58;
          1: d = 59;
          2: d = 60;
          3: d = 364;
          default: d = 365;
        endcase
        t = (64'(y) * 365 + (y + 1) / 4 + d) * SecsPerDay + $urandom_range(86399);
        if (t > 64'hFFFF_FFFF) t = 64'($urandom());
      end
    endcase
    return t[31:0];
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_tready) begin
      s_tvalid <= 1'b1;
    end else begin
      if (s_tvalid) begin
        expected_dates.push_back(to_calendar(s_tdata));
        items_sent++;
      end
      if (pending_seconds.size() != 0 && $urandom_range(99) >= idle_pct) begin
        s_tdata  <= pending_seconds.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    calendar_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_dates.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = expected_dates.pop_front();
        check_field("second_of_minute", want.second_of_minute, got.second_of_minute);
        check_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
        check_field("hour_of_day", want.hour_of_day, got.hour_of_day);
        check_field("day_of_month", want.day_of_month, got.day_of_month);
        check_field("month_number", want.month_number, got.month_number);
        check_field("years_since_1900", want.years_since_1900, got.years_since_1900);
        check_field("day_of_year", want.day_of_year, got.day_of_year);
        check_field("weekday", want.weekday, got.weekday);
        check_field("pad", want.pad, got.pad);
        dates_checked++;
      end
    end
  end

  task automatic drain();
    while (pending_seconds.size() != 0 || s_tvalid || expected_dates.size() != 0)
      @(posedge clk);
  endtask

  task automatic load_random(input int unsigned count);
    repeat (count) pending_seconds.push_back(pick_seconds());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // epoch, unit rollovers, leap days including 2100, end of the 32-bit range
    pending_seconds = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999, 32'd63072000, 32'd68169600, 32'd94608000, 32'd951782400,
      32'd951868800, 32'd978307199, 32'h7FFF_FFFF, 32'h8000_0000, 32'd4107456000,
      32'd4107542400, 32'd4107628800, 32'd4133980800, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
      32'hAAAA_AAAA, 32'h5555_5555
    };
    drain();

    load_random(400);
    repeat (30) @(posedge clk);
    hold_req <= 1'b1;
    drain();

    idle_pct = 48;
    load_random(400);
    drain();

    idle_pct  = 0;
    stall_pct = 48;
    load_random(400);
    drain();

    idle_pct  = 11;
    stall_pct = 11;
    load_random(425);
    drain();

    repeat (EndLatency) @(posedge clk);
    $display("Converted %0d timestamps and checked %0d calendar dates", items_sent,
             dates_checked);
    $display("Covered rollovers, leap days through 2100, full 32-bit range, stalls and gaps");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/ep2c_pkg.sv
rtl/core/ep2c_divc.sv
rtl/core/epoch_seconds_to_calendar.sv
test/tb_epoch_seconds_to_calendar.sv
